>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Each macro expects clk and rst_n to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SITDA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SITDA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared widths, character codes and types of the decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_W = 32;             // input integer width
  localparam int DIGITS  = 10;             // decimal digits of a 32-bit magnitude
  localparam int BCD_W   = 4 * DIGITS;     // packed BCD width
  localparam int CNT_W   = $clog2(VALUE_W); // shift step counter
  localparam int REM_W   = $clog2(DIGITS + 1); // remaining digit counter
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Status of the shift-add-3 unit
  typedef struct packed {
    logic busy;
    logic done;
  } dabble_stat_t;

  // Character emitter sequence
  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SKIP,
    EM_SIGN,
    EM_DIGIT
  } emit_state_t;

endpackage

>>> rtl/core/sitda_dabble.sv
// ----------------------------------------------------------------------------
// sitda_dabble
// Bit-serial binary to BCD conversion (shift and add 3), one bit per cycle.
// ----------------------------------------------------------------------------
module sitda_dabble (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [sitda_pkg::VALUE_W-1:0]    mag,
  output sitda_pkg::dabble_stat_t          stat,
  output logic [sitda_pkg::BCD_W-1:0]      bcd
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [sitda_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [sitda_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [sitda_pkg::BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [sitda_pkg::BCD_W-1:0]   adj;

  // Correct every BCD digit of 5 or more before the next doubling
  always_comb begin
    for (int i = 0; i < sitda_pkg::DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Load on start, then shift one magnitude bit into the BCD register a cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      bin_nxt  = mag;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt = {adj[sitda_pkg::BCD_W-2:0], bin_r[sitda_pkg::VALUE_W-1]};
      bin_nxt = {bin_r[sitda_pkg::VALUE_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sitda_pkg::CNT_W'(sitda_pkg::VALUE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath holds no reset
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

>>> rtl/core/sitda_emit.sv
// ----------------------------------------------------------------------------
// sitda_emit
// Drops leading zero digits, then sends sign and digits one per transaction.
// ----------------------------------------------------------------------------
module sitda_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic                              neg,
  input  logic [sitda_pkg::BCD_W-1:0]       bcd,
  output logic                              busy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sitda_pkg::CHAR_W-1:0]      out_char_code,
  output logic                              out_last
);

  sitda_pkg::emit_state_t        state_r, state_nxt;
  logic [sitda_pkg::BCD_W-1:0]   dig_r, dig_nxt;
  logic [sitda_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic                          neg_r, neg_nxt;
  logic                          ov_r, ov_nxt;
  logic [sitda_pkg::CHAR_W-1:0]  ch_r, ch_nxt;
  logic                          last_r, last_nxt;
  logic                          slot;
  logic [3:0]                    top;

  assign slot = !ov_r || out_ready;
  assign top  = dig_r[sitda_pkg::BCD_W-1 -: 4];

  // Sequence: skip zeros, optional sign, then digits
  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    ov_nxt    = ov_r && !out_ready;
    ch_nxt    = ch_r;
    last_nxt  = last_r;
    case (state_r)
      sitda_pkg::EM_IDLE: begin
        if (load) begin
          dig_nxt   = bcd;
          rem_nxt   = sitda_pkg::REM_W'(sitda_pkg::DIGITS);
          neg_nxt   = neg;
          state_nxt = sitda_pkg::EM_SKIP;
        end
      end
      sitda_pkg::EM_SKIP: begin
        // Drop a leading zero, but always keep the units digit
        if (top == 4'd0 && rem_r != sitda_pkg::REM_W'(1)) begin
          dig_nxt = {dig_r[sitda_pkg::BCD_W-5:0], 4'd0};
          rem_nxt = rem_r - 1'b1;
        end else if (neg_r) begin
          state_nxt = sitda_pkg::EM_SIGN;
        end else begin
          state_nxt = sitda_pkg::EM_DIGIT;
        end
      end
      sitda_pkg::EM_SIGN: begin
        if (slot) begin
          ov_nxt    = 1'b1;
          ch_nxt    = sitda_pkg::CHAR_MINUS;
          last_nxt  = 1'b0;
          state_nxt = sitda_pkg::EM_DIGIT;
        end
      end
      sitda_pkg::EM_DIGIT: begin
        if (slot) begin
          ov_nxt   = 1'b1;
          ch_nxt   = sitda_pkg::CHAR_ZERO + {4'd0, top};
          last_nxt = (rem_r == sitda_pkg::REM_W'(1));
          dig_nxt  = {dig_r[sitda_pkg::BCD_W-5:0], 4'd0};
          rem_nxt  = rem_r - 1'b1;
          if (rem_r == sitda_pkg::REM_W'(1)) begin
            state_nxt = sitda_pkg::EM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sitda_pkg::EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sitda_pkg::EM_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers hold no reset
  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
  end

  assign busy          = (state_r != sitda_pkg::EM_IDLE) || ov_r;
  assign out_valid     = ov_r;
  assign out_char_code = ch_r;
  assign out_last      = last_r;

endmodule

>>> rtl/core/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Prints a 32-bit two's complement integer as decimal ASCII, one character
// per output transaction, most significant first, last character flagged.
// ----------------------------------------------------------------------------
// One value is converted at a time. After a value is accepted, a shift-add-3
// unit shifts the magnitude in one bit at a time to form ten BCD digits and
// hands them over through its registered done flag. The emitter then drops
// each suppressed leading zero in turn, picks the sign, and sends one
// character per cycle while out_ready is high. The time to the last character
// and to the next accepted value is set by the bit-serial BCD loop, the zero
// scan and the character count. A negative value is led by '-', zero prints
// as "0", and the most negative value prints exactly. in_ready returns high
// the cycle after the last character is taken.
module signed_int_to_decimal_ascii (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [sitda_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sitda_pkg::CHAR_W-1:0]       out_char_code,
  output logic                               out_last
);

  logic                           accept;
  logic [sitda_pkg::VALUE_W-1:0]  raw;
  logic [sitda_pkg::VALUE_W-1:0]  mag;
  logic                           neg_r, neg_nxt;
  sitda_pkg::dabble_stat_t        dstat;
  logic [sitda_pkg::BCD_W-1:0]    bcd;
  logic                           emit_busy;

  // Take a new value only when both units are free
  assign in_ready = !dstat.busy && !dstat.done && !emit_busy;
  assign accept   = in_valid && in_ready;

  // Magnitude; the most negative value maps onto its own unsigned pattern
  assign raw = in_value;
  assign mag = raw[sitda_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;

  // Hold the sign until the digits are handed over
  assign neg_nxt = accept ? raw[sitda_pkg::VALUE_W-1] : neg_r;

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
  end

  sitda_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .mag   (mag),
    .stat  (dstat),
    .bcd   (bcd)
  );

  sitda_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (dstat.done),
    .neg           (neg_r),
    .bcd           (bcd),
    .busy          (emit_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

>>> rtl/core/sitda_checker.sv
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks of the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sitda_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sitda_pkg::CHAR_W-1:0]  out_char_code,
  input logic                          out_last
);

  logic                        out_stall;
  logic [sitda_pkg::CHAR_W:0]  out_word;
  logic                        char_legal;
  logic                        sign_out;

  // Condense the output channel into the terms the checks need
  assign out_stall  = out_valid && !out_ready;
  assign out_word   = {out_char_code, out_last};
  assign char_legal = (out_char_code == sitda_pkg::CHAR_MINUS) ||
                      ((out_char_code >= sitda_pkg::CHAR_ZERO) &&
                       (out_char_code <= (sitda_pkg::CHAR_ZERO + 8'd9)));
  assign sign_out   = out_valid && (out_char_code == sitda_pkg::CHAR_MINUS);

  // A stalled character holds
  `SITDA_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_word))

  // Only '-' or a decimal digit is ever sent
  `SITDA_ASSERT_IMP(a_char_set, out_valid, char_legal)

  // The sign is never the final character
  `SITDA_ASSERT_IMP(a_sign_not_last, sign_out, !out_last)

  // One value at a time: no new transaction right after one is taken
  `SITDA_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_char_code (out_char_code),
  .out_last      (out_last)
);
